/* design/tcc_pkg.sv */
// Shared types and constants of the text console character engine.
`timescale 1ns / 1ps

package tcc_pkg;

  localparam int KIND_W      = 2;
  localparam int CHAR_W      = 8;
  localparam int COL_W       = 7;
  localparam int ROW_W       = 5;
  localparam int ATTR_W      = 8;
  localparam int CELL_W      = 16;
  localparam int OP_W        = 4;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;
  localparam int FIFO_DEPTH  = 2;

  localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd3;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0d;
  localparam logic [CHAR_W-1:0] CH_DELETE    = 8'h7f;

  localparam logic [CFG_INDEX_W-1:0] REG_TEXT_ATTRIBUTE  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NEWLINE_RETURNS = 1'd1;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;

  // command classes handed from front to back
  localparam logic [OP_W-1:0] OP_PRINT     = 4'd0;
  localparam logic [OP_W-1:0] OP_NEWLINE   = 4'd1;
  localparam logic [OP_W-1:0] OP_RETURN    = 4'd2;
  localparam logic [OP_W-1:0] OP_BACKSPACE = 4'd3;
  localparam logic [OP_W-1:0] OP_DELETE    = 4'd4;
  localparam logic [OP_W-1:0] OP_TAB       = 4'd5;
  localparam logic [OP_W-1:0] OP_CLEAR     = 4'd6;
  localparam logic [OP_W-1:0] OP_READ      = 4'd7;
  localparam logic [OP_W-1:0] OP_WRITE     = 4'd8;
  localparam logic [OP_W-1:0] OP_SKIP      = 4'd9;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] char_code;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } cmd_t;

  typedef struct packed {
    logic [ATTR_W-1:0] text_attribute;
    logic              newline_returns;
  } cfg_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [CELL_W-1:0] cell_value;
    logic              scrolled;
  } res_t;

endpackage

/* design/tcc_fifo.sv */
// Small request queue used between the front, the back and the result port.
`timescale 1ns / 1ps

module tcc_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = $clog2(tcc_pkg::FIFO_DEPTH);

  logic [WIDTH-1:0] slots [tcc_pkg::FIFO_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (PW+1)'(tcc_pkg::FIFO_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

/* design/tcc_front.sv */
// Intake side: accepts requests and classifies them into back-end commands.
`timescale 1ns / 1ps

module tcc_front #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 24
) (
  input  logic                        push,
  input  logic [tcc_pkg::KIND_W-1:0]  kind,
  input  logic [tcc_pkg::CHAR_W-1:0]  char_code,
  input  logic [tcc_pkg::COL_W-1:0]   col,
  input  logic [tcc_pkg::ROW_W-1:0]   row,
  output logic                        full,
  input  logic                        cmd_full,
  input  logic                        init_busy,
  output logic                        cmd_push,
  output tcc_pkg::cmd_t               cmd
);

  logic in_range;

  assign in_range = (col < COLUMNS) && (row < ROWS);
  assign full     = cmd_full || init_busy;
  assign cmd_push = push && !full;

  always_comb begin
    cmd.char_code = char_code;
    cmd.col       = col;
    cmd.row       = row;
    unique case (kind)
      tcc_pkg::KIND_PUT: begin
        unique case (char_code)
          tcc_pkg::CH_NEWLINE:   cmd.op = tcc_pkg::OP_NEWLINE;
          tcc_pkg::CH_RETURN:    cmd.op = tcc_pkg::OP_RETURN;
          tcc_pkg::CH_BACKSPACE: cmd.op = tcc_pkg::OP_BACKSPACE;
          tcc_pkg::CH_DELETE:    cmd.op = tcc_pkg::OP_DELETE;
          tcc_pkg::CH_TAB:       cmd.op = tcc_pkg::OP_TAB;
          default:               cmd.op = tcc_pkg::OP_PRINT;
        endcase
      end
      tcc_pkg::KIND_CLEAR: cmd.op = tcc_pkg::OP_CLEAR;
      tcc_pkg::KIND_READ:  cmd.op = in_range ? tcc_pkg::OP_READ : tcc_pkg::OP_SKIP;
      default:             cmd.op = in_range ? tcc_pkg::OP_WRITE : tcc_pkg::OP_SKIP;
    endcase
  end

endmodule

/* design/tcc_back.sv */
// Execution side: cell memory, cursor, and the scroll/clear sweep sequencer.
`timescale 1ns / 1ps

module tcc_back #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 24,
  parameter int TAB_WIDTH = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  tcc_pkg::cfg_t cfg,
  input  logic          cmd_empty,
  input  tcc_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic          res_full,
  output logic          res_push,
  output tcc_pkg::res_t res,
  output logic          init_busy
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int CXW   = $clog2(COLUMNS + TAB_WIDTH);
  localparam int RXW   = $clog2(ROWS + 1);
  localparam int PW    = $clog2(TAB_WIDTH);

  localparam logic [PW-1:0] LAST_PHASE = PW'((COLUMNS - 1) % TAB_WIDTH);
  localparam logic [PW-1:0] PHASE_TOP  = PW'(TAB_WIDTH - 1);
  localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
  localparam logic [AW-1:0] LAST_COPY  = AW'(CELLS - COLUMNS - 1);
  localparam logic [AW-1:0] BOTTOM_ROW = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] ROW_STRIDE = AW'(COLUMNS);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_SCROLL = 3'd3;
  localparam logic [2:0] S_FILL   = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  logic [2:0]                   state;
  logic [CW-1:0]                cur_col;
  logic [RW-1:0]                cur_row;
  logic [PW-1:0]                phase;   // cursor column modulo tab width
  logic [AW-1:0]                ptr;
  logic [tcc_pkg::CELL_W-1:0]   cells [CELLS];
  logic [tcc_pkg::CELL_W-1:0]   rd_data;
  logic [tcc_pkg::CELL_W-1:0]   value;
  logic                         scrolled;

  logic                         start;
  logic [AW-1:0]                cursor_addr;
  logic [AW-1:0]                pos_addr;
  logic [tcc_pkg::CELL_W-1:0]   blank;

  logic [CXW-1:0]               col_step;
  logic [RXW-1:0]               row_step;
  logic [PW-1:0]                phase_step;
  logic [CW-1:0]                col_next;
  logic [RW-1:0]                row_next;
  logic [PW-1:0]                phase_next;
  logic                         scroll_next;
  logic                         put_write;
  logic [tcc_pkg::CHAR_W-1:0]   put_char;

  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [tcc_pkg::CELL_W-1:0]   mem_wdata;
  logic [AW-1:0]                rd_addr;

  assign start       = (state == S_IDLE) && !cmd_empty && !res_full;
  assign cmd_pop     = start;
  assign init_busy   = (state == S_INIT);
  assign res_push    = (state == S_EMIT);
  assign cursor_addr = AW'(cur_row) * ROW_STRIDE + AW'(cur_col);
  assign pos_addr    = AW'(cmd.row) * ROW_STRIDE + AW'(cmd.col);
  assign blank       = {cfg.text_attribute, tcc_pkg::CHAR_W'(0)};

  assign res.cursor_col = tcc_pkg::COL_W'(cur_col);
  assign res.cursor_row = tcc_pkg::ROW_W'(cur_row);
  assign res.cell_value = value;
  assign res.scrolled   = scrolled;

  // cursor motion for put commands
  always_comb begin
    col_step   = CXW'(cur_col);
    row_step   = RXW'(cur_row);
    phase_step = phase;
    put_write  = 1'b0;
    put_char   = cmd.char_code;
    unique case (cmd.op)
      tcc_pkg::OP_NEWLINE: begin
        row_step = RXW'(cur_row) + 1'b1;
        if (cfg.newline_returns) begin
          col_step   = '0;
          phase_step = '0;
        end
      end
      tcc_pkg::OP_RETURN: begin
        col_step   = '0;
        phase_step = '0;
      end
      tcc_pkg::OP_BACKSPACE: begin
        if (cur_col != '0) begin
          col_step   = CXW'(cur_col) - 1'b1;
          phase_step = (phase == '0) ? PHASE_TOP : phase - 1'b1;
        end else if (cur_row != '0) begin
          col_step   = CXW'(COLUMNS - 1);
          phase_step = LAST_PHASE;
          row_step   = RXW'(cur_row) - 1'b1;
        end
      end
      tcc_pkg::OP_DELETE: begin
        put_write = 1'b1;
        put_char  = '0;
      end
      tcc_pkg::OP_TAB: begin
        col_step   = CXW'(cur_col) + CXW'(TAB_WIDTH) - CXW'(phase);
        phase_step = '0;
      end
      tcc_pkg::OP_PRINT: begin
        put_write  = 1'b1;
        col_step   = CXW'(cur_col) + 1'b1;
        phase_step = (phase == PHASE_TOP) ? '0 : phase + 1'b1;
      end
      default: ;
    endcase
    if (col_step > CXW'(COLUMNS - 1)) begin
      col_step   = '0;
      phase_step = '0;
      row_step   = row_step + 1'b1;
    end
    scroll_next = (row_step > RXW'(ROWS - 1));
    col_next    = CW'(col_step);
    phase_next  = phase_step;
    row_next    = scroll_next ? RW'(ROWS - 1) : RW'(row_step);
  end

  // memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr;
    mem_wdata = blank;
    rd_addr   = '0;
    unique case (state)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
      end
      S_IDLE: begin
        // a scroll needs the first row-one cell ready on entry
        rd_addr = (cmd.op == tcc_pkg::OP_READ) ? pos_addr : ROW_STRIDE;
        if (start) begin
          if (cmd.op == tcc_pkg::OP_WRITE) begin
            mem_we    = 1'b1;
            mem_waddr = pos_addr;
            mem_wdata = {cfg.text_attribute, cmd.char_code};
          end else if (put_write) begin
            mem_we    = 1'b1;
            mem_waddr = cursor_addr;
            mem_wdata = {cfg.text_attribute, put_char};
          end
        end
      end
      S_SCROLL: begin
        mem_we    = 1'b1;
        mem_wdata = rd_data;
        rd_addr   = (ptr == LAST_COPY) ? '0 : ptr + ROW_STRIDE + 1'b1;
      end
      S_FILL: begin
        mem_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cells[mem_waddr] <= mem_wdata;
    end
    rd_data <= cells[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_INIT;
      ptr     <= '0;
      cur_col <= '0;
      cur_row <= '0;
      phase   <= '0;
    end else begin
      unique case (state)
        S_INIT: begin
          if (ptr == LAST_CELL) begin
            ptr   <= '0;
            state <= S_IDLE;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        S_IDLE: begin
          if (start) begin
            value <= '0;
            unique case (cmd.op)
              tcc_pkg::OP_CLEAR: begin
                cur_col  <= '0;
                cur_row  <= '0;
                phase    <= '0;
                ptr      <= '0;
                scrolled <= 1'b0;
                state    <= S_FILL;
              end
              tcc_pkg::OP_READ: begin
                scrolled <= 1'b0;
                state    <= S_READ;
              end
              tcc_pkg::OP_WRITE, tcc_pkg::OP_SKIP: begin
                scrolled <= 1'b0;
                state    <= S_EMIT;
              end
              default: begin
                cur_col  <= col_next;
                cur_row  <= row_next;
                phase    <= phase_next;
                ptr      <= '0;
                scrolled <= scroll_next;
                state    <= scroll_next ? S_SCROLL : S_EMIT;
              end
            endcase
          end
        end
        S_READ: begin
          value <= rd_data;
          state <= S_EMIT;
        end
        S_SCROLL: begin
          if (ptr == LAST_COPY) begin
            ptr   <= BOTTOM_ROW;
            state <= S_FILL;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        S_FILL: begin
          if (ptr == LAST_CELL) begin
            ptr   <= '0;
            state <= S_EMIT;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        S_EMIT: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* design/text_console_char_engine.sv */
// Top level of the text console character engine.
`timescale 1ns / 1ps

// Text console of COLUMNS x ROWS 16-bit cells (attribute over character) with a cursor.
// Requests enter through a two-entry queue and results leave through another, so both
// sides stall independently. All cell traffic goes through one cell memory with a
// write port and a registered read port. A clear blanks every cell and a put that
// scrolls moves rows up one and blanks the bottom row, one cell copied or blanked
// per cycle. After reset the memory is swept to zero, during which full stays high;
// configuration writes are taken at any time.
module text_console_char_engine #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 24,
  parameter int TAB_WIDTH = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [tcc_pkg::KIND_W-1:0]      kind,
  input  logic [tcc_pkg::CHAR_W-1:0]      char_code,
  input  logic [tcc_pkg::COL_W-1:0]       col,
  input  logic [tcc_pkg::ROW_W-1:0]       row,
  input  logic                            cfg_write,
  input  logic [tcc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tcc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            empty,
  input  logic                            pop,
  output logic [tcc_pkg::COL_W-1:0]       cursor_col,
  output logic [tcc_pkg::ROW_W-1:0]       cursor_row,
  output logic [tcc_pkg::CELL_W-1:0]      cell_value,
  output logic                            scrolled
);

  tcc_pkg::cfg_t cfg;
  tcc_pkg::cmd_t cmd_in;
  tcc_pkg::cmd_t cmd_q;
  tcc_pkg::res_t res_in;
  tcc_pkg::res_t res_q;
  logic          cmd_push;
  logic          cmd_full;
  logic          cmd_empty;
  logic          cmd_pop;
  logic          res_push;
  logic          res_full;
  logic          init_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.text_attribute  <= tcc_pkg::ATTR_RESET;
      cfg.newline_returns <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tcc_pkg::REG_TEXT_ATTRIBUTE:  cfg.text_attribute  <= cfg_data;
        tcc_pkg::REG_NEWLINE_RETURNS: cfg.newline_returns <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tcc_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .push      (push),
    .kind      (kind),
    .char_code (char_code),
    .col       (col),
    .row       (row),
    .full      (full),
    .cmd_full  (cmd_full),
    .init_busy (init_busy),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in)
  );

  tcc_fifo #(
    .WIDTH ($bits(tcc_pkg::cmd_t))
  ) u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_q),
    .empty (cmd_empty)
  );

  tcc_back #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_q),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in),
    .init_busy (init_busy)
  );

  tcc_fifo #(
    .WIDTH ($bits(tcc_pkg::res_t))
  ) u_res_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_q),
    .empty (empty)
  );

  assign cursor_col = res_q.cursor_col;
  assign cursor_row = res_q.cursor_row;
  assign cell_value = res_q.cell_value;
  assign scrolled   = res_q.scrolled;

endmodule

/* design/tcc_checker.sv */
// Port-level checks of the text console character engine, bound to the top level.
`timescale 1ns / 1ps

module tcc_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 24
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       full,
  input logic                       empty,
  input logic                       pop,
  input logic [tcc_pkg::COL_W-1:0]  cursor_col,
  input logic [tcc_pkg::ROW_W-1:0]  cursor_row,
  input logic [tcc_pkg::CELL_W-1:0] cell_value,
  input logic                       scrolled
);

  // memory sweep holds intake off and nothing is pending right after reset
  a_reset_sweep: assert property (@(posedge clk) $past(rst) && !rst |-> full && empty)
    else $error("intake open or result pending right after reset");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (cursor_col < COLUMNS))
    else $error("reported cursor column beyond last column");

  a_scroll_row: assert property (@(posedge clk) disable iff (rst)
    !empty && scrolled |-> (cursor_row == tcc_pkg::ROW_W'(ROWS - 1)))
    else $error("scrolled result not on last row");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable({cursor_col, cursor_row, cell_value, scrolled}))
    else $error("waiting result changed or vanished");

endmodule

bind text_console_char_engine tcc_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcc_checker (
  .clk        (clk),
  .rst        (rst),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .cursor_col (cursor_col),
  .cursor_row (cursor_row),
  .cell_value (cell_value),
  .scrolled   (scrolled)
);
